FILE: rtl/opm_pkg.sv
// ----------------------------------------------------------------------------
// opm_pkg
// Shared types and constants for the off-centre projection matrix core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package opm_pkg;

  localparam int QW       = 32;
  localparam int NUM_W    = 64;
  localparam int DEN_W    = 34;
  localparam int UD_W     = 32;
  localparam int DIV_BITS = 32;
  localparam int NLANES   = 6;
  localparam int LANE_LAT = DIV_BITS + 1;

  localparam logic signed [QW-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [QW-1:0] Q_M_ONE = 32'shFFFF_0000;
  localparam logic signed [QW-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN   = 32'sh8000_0000;

  localparam logic [0:0] CFG_CONVENTION  = 1'b0;
  localparam logic [0:0] CFG_PERSPECTIVE = 1'b1;

  localparam int L_SX = 0;
  localparam int L_SY = 1;
  localparam int L_KX = 2;
  localparam int L_KY = 3;
  localparam int L_DS = 4;
  localparam int L_DO = 5;

  typedef enum logic [1:0] {
    CONV_LH_Z01 = 2'd0,
    CONV_RH_Z01 = 2'd1,
    CONV_RH_ZPM = 2'd2
  } conv_t;

  typedef struct packed {
    logic signed [QW-1:0] left_edge;
    logic signed [QW-1:0] right_edge;
    logic signed [QW-1:0] bottom_edge;
    logic signed [QW-1:0] top_edge;
    logic signed [QW-1:0] near_depth;
    logic signed [QW-1:0] far_depth;
  } in_item_t;

  typedef struct packed {
    logic signed [QW-1:0] scale_x;
    logic signed [QW-1:0] scale_y;
    logic signed [QW-1:0] skew_x;
    logic signed [QW-1:0] skew_y;
    logic signed [QW-1:0] depth_scale;
    logic signed [QW-1:0] w_from_z;
    logic signed [QW-1:0] offset_x;
    logic signed [QW-1:0] offset_y;
    logic signed [QW-1:0] depth_offset;
    logic signed [QW-1:0] w_constant;
    logic                 degenerate;
  } out_item_t;

  typedef struct packed {
    logic  valid;
    logic  degen;
    logic  persp;
    conv_t conv;
  } side_t;

  typedef struct packed {
    logic                neg;
    logic                sat;
    logic [UD_W-1:0]     rem;
    logic [DIV_BITS-1:0] num_lo;
    logic [UD_W-1:0]     ud;
    logic [DIV_BITS-1:0] quo;
  } div_job_t;

endpackage

FILE: rtl/opm_front.sv
// ----------------------------------------------------------------------------
// opm_front
// Extents, sums and near*far product, then numerator and denominator
// selection for the six divider lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_take,
  input  opm_pkg::in_item_t                in_data,
  input  opm_pkg::conv_t                   conv,
  input  logic                             persp,
  output opm_pkg::side_t                   side_o,
  output logic signed [opm_pkg::NUM_W-1:0] num_o [opm_pkg::NLANES],
  output logic signed [opm_pkg::DEN_W-1:0] den_o [opm_pkg::NLANES]
);

  logic signed [32:0] w_r, h_r, d_r, slr_r, stb_r, sfn_r;
  logic signed [31:0] n_r;
  logic signed [63:0] nf_r;
  opm_pkg::side_t     side_a_r, side_a_nxt, side_b_r;
  logic signed [opm_pkg::NUM_W-1:0] num_r [opm_pkg::NLANES];
  logic signed [opm_pkg::DEN_W-1:0] den_r [opm_pkg::NLANES];
  logic signed [opm_pkg::NUM_W-1:0] num_nxt [opm_pkg::NLANES];
  logic signed [opm_pkg::DEN_W-1:0] den_nxt [opm_pkg::NLANES];

  logic signed [32:0] w_nxt, h_nxt, d_nxt;
  logic signed [31:0] nn, ff;

  always_comb begin
    nn    = in_data.near_depth;
    ff    = in_data.far_depth;
    w_nxt = 33'(in_data.right_edge) - 33'(in_data.left_edge);
    h_nxt = 33'(in_data.top_edge) - 33'(in_data.bottom_edge);
    d_nxt = 33'(ff) - 33'(nn);
    side_a_nxt.valid = in_take;
    side_a_nxt.persp = persp;
    side_a_nxt.conv  = conv;
    side_a_nxt.degen = (w_nxt == '0) || (h_nxt == '0) || (d_nxt == '0) ||
                       (persp && ((nn <= 0) || (ff <= 0)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      d_r   <= d_nxt;
      slr_r <= 33'(in_data.left_edge) + 33'(in_data.right_edge);
      stb_r <= 33'(in_data.top_edge) + 33'(in_data.bottom_edge);
      sfn_r <= 33'(ff) + 33'(nn);
      n_r   <= nn;
      nf_r  <= 64'(nn) * 64'(ff);
    end
  end

  logic signed [63:0] w64, h64, d64, n16, slr16, stb16, sfn16, f16;

  always_comb begin
    w64   = 64'(w_r);
    h64   = 64'(h_r);
    d64   = 64'(d_r);
    n16   = 64'(n_r) <<< 16;
    f16   = (64'(sfn_r) - 64'(n_r)) <<< 16;
    slr16 = 64'(slr_r) <<< 16;
    stb16 = 64'(stb_r) <<< 16;
    sfn16 = 64'(sfn_r) <<< 16;
    for (int i = 0; i < opm_pkg::NLANES; i++) begin
      num_nxt[i] = '0;
      den_nxt[i] = '0;
    end
    den_nxt[opm_pkg::L_SX] = opm_pkg::DEN_W'(w64);
    den_nxt[opm_pkg::L_SY] = opm_pkg::DEN_W'(h64);
    den_nxt[opm_pkg::L_KX] = opm_pkg::DEN_W'(w64);
    den_nxt[opm_pkg::L_KY] = opm_pkg::DEN_W'(h64);
    den_nxt[opm_pkg::L_DS] = opm_pkg::DEN_W'(d64);
    den_nxt[opm_pkg::L_DO] = opm_pkg::DEN_W'(d64);
    if (side_a_r.persp) begin
      num_nxt[opm_pkg::L_SX] = n16 <<< 1;
      num_nxt[opm_pkg::L_SY] = n16 <<< 1;
      unique case (side_a_r.conv)
        opm_pkg::CONV_LH_Z01: begin
          num_nxt[opm_pkg::L_KX] = -slr16;
          num_nxt[opm_pkg::L_KY] = -stb16;
          num_nxt[opm_pkg::L_DS] = f16;
          num_nxt[opm_pkg::L_DO] = -nf_r;
        end
        opm_pkg::CONV_RH_Z01: begin
          num_nxt[opm_pkg::L_KX] = slr16;
          num_nxt[opm_pkg::L_KY] = stb16;
          num_nxt[opm_pkg::L_DS] = f16;
          num_nxt[opm_pkg::L_DO] = nf_r;
          den_nxt[opm_pkg::L_DS] = -opm_pkg::DEN_W'(d64);
          den_nxt[opm_pkg::L_DO] = -opm_pkg::DEN_W'(d64);
        end
        default: begin
          num_nxt[opm_pkg::L_KX] = slr16;
          num_nxt[opm_pkg::L_KY] = stb16;
          num_nxt[opm_pkg::L_DS] = -sfn16;
          num_nxt[opm_pkg::L_DO] = -(nf_r <<< 1);
        end
      endcase
    end else begin
      num_nxt[opm_pkg::L_SX] = 64'sh2_0000_0000;
      num_nxt[opm_pkg::L_SY] = 64'sh2_0000_0000;
      num_nxt[opm_pkg::L_KX] = -slr16;
      num_nxt[opm_pkg::L_KY] = -stb16;
      unique case (side_a_r.conv)
        opm_pkg::CONV_LH_Z01: begin
          num_nxt[opm_pkg::L_DS] = 64'sh1_0000_0000;
          num_nxt[opm_pkg::L_DO] = -n16;
        end
        opm_pkg::CONV_RH_Z01: begin
          num_nxt[opm_pkg::L_DS] = 64'sh1_0000_0000;
          num_nxt[opm_pkg::L_DO] = n16;
          den_nxt[opm_pkg::L_DS] = -opm_pkg::DEN_W'(d64);
          den_nxt[opm_pkg::L_DO] = -opm_pkg::DEN_W'(d64);
        end
        default: begin
          num_nxt[opm_pkg::L_DS] = -64'sh2_0000_0000;
          num_nxt[opm_pkg::L_DO] = -sfn16;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
      side_b_r <= '0;
    end else if (en) begin
      side_a_r <= side_a_nxt;
      side_b_r <= side_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign side_o = side_b_r;
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

FILE: rtl/opm_div_cell.sv
// ----------------------------------------------------------------------------
// opm_div_cell
// One restoring-division cell: retires one quotient bit per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opm_div_cell (
  input  logic                clk,
  input  logic                en,
  input  opm_pkg::div_job_t   job_i,
  output opm_pkg::div_job_t   job_o
);

  opm_pkg::div_job_t job_r, job_nxt;
  logic [opm_pkg::UD_W:0] trial, diff;
  logic                   ge;

  always_comb begin
    trial   = {job_i.rem, job_i.num_lo[opm_pkg::DIV_BITS-1]};
    diff    = trial - {1'b0, job_i.ud};
    ge      = trial >= {1'b0, job_i.ud};
    job_nxt = job_i;
    job_nxt.rem    = ge ? diff[opm_pkg::UD_W-1:0] : trial[opm_pkg::UD_W-1:0];
    job_nxt.num_lo = {job_i.num_lo[opm_pkg::DIV_BITS-2:0], 1'b0};
    job_nxt.quo    = {job_i.quo[opm_pkg::DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r <= job_nxt;
    end
  end

  assign job_o = job_r;

endmodule

FILE: rtl/opm_div_lane.sv
// ----------------------------------------------------------------------------
// opm_div_lane
// Signed rounded divide with saturation: magnitude stage, a chain of
// division cells, then round-to-nearest and clamp to Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opm_div_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [opm_pkg::NUM_W-1:0] num,
  input  logic signed [opm_pkg::DEN_W-1:0] den,
  output logic signed [opm_pkg::QW-1:0]    quo
);

  opm_pkg::div_job_t job_r, job_nxt;
  opm_pkg::div_job_t chain [opm_pkg::DIV_BITS+1];
  logic [opm_pkg::NUM_W-1:0] un;
  logic [opm_pkg::DEN_W-1:0] ud_full;

  always_comb begin
    un      = num[opm_pkg::NUM_W-1] ? (~num + 1'b1) : num;
    ud_full = den[opm_pkg::DEN_W-1] ? (~den + 1'b1) : den;
    job_nxt.neg    = num[opm_pkg::NUM_W-1] ^ den[opm_pkg::DEN_W-1];
    job_nxt.ud     = ud_full[opm_pkg::UD_W-1:0];
    job_nxt.sat    = un >= {ud_full[opm_pkg::UD_W-1:0], {opm_pkg::DIV_BITS{1'b0}}};
    job_nxt.rem    = un[opm_pkg::NUM_W-1 -: opm_pkg::UD_W];
    job_nxt.num_lo = un[opm_pkg::DIV_BITS-1:0];
    job_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r <= job_nxt;
    end
  end

  assign chain[0] = job_r;

  for (genvar g = 0; g < opm_pkg::DIV_BITS; g++) begin : g_cell
    opm_div_cell u_cell (
      .clk   (clk),
      .en    (en),
      .job_i (chain[g]),
      .job_o (chain[g+1])
    );
  end

  opm_pkg::div_job_t       last;
  logic                    up;
  logic [opm_pkg::QW:0]    q33;

  always_comb begin
    last = chain[opm_pkg::DIV_BITS];
    up   = {last.rem, 1'b0} >= {1'b0, last.ud};
    q33  = {1'b0, last.quo} + {{opm_pkg::QW{1'b0}}, up};
    if (last.sat) begin
      quo = last.neg ? opm_pkg::Q_MIN : opm_pkg::Q_MAX;
    end else if (last.neg) begin
      quo = (q33 >= 33'h0_8000_0000) ? opm_pkg::Q_MIN :
            opm_pkg::QW'(~q33[opm_pkg::QW-1:0] + 1'b1);
    end else begin
      quo = (q33 > 33'h0_7FFF_FFFF) ? opm_pkg::Q_MAX : opm_pkg::QW'(q33[opm_pkg::QW-1:0]);
    end
  end

endmodule

FILE: rtl/offcenter_projection_matrix_core.sv
// ----------------------------------------------------------------------------
// offcenter_projection_matrix_core
// Off-centre frustum or orthographic projection matrix in Q16.16.
// Pipeline: front extent and lane-operand registers, lane magnitude register, division cells, output register.
// Throughput: one item per cycle while the output is not stalled; six lanes of 32 division cells each.
// Reset: convention right-handed -1..1, perspective mode on, pipeline empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module offcenter_projection_matrix_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  opm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output opm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [1:0]         cfg_wdata
);

  logic           en;
  opm_pkg::conv_t conv_r;
  logic           persp_r;
  logic           out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r  <= opm_pkg::CONV_RH_ZPM;
      persp_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        opm_pkg::CFG_CONVENTION:  conv_r  <= opm_pkg::conv_t'(cfg_wdata);
        opm_pkg::CFG_PERSPECTIVE: persp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  opm_pkg::side_t                   side_b;
  logic signed [opm_pkg::NUM_W-1:0] num [opm_pkg::NLANES];
  logic signed [opm_pkg::DEN_W-1:0] den [opm_pkg::NLANES];
  logic signed [opm_pkg::QW-1:0]    res [opm_pkg::NLANES];

  opm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_take (in_valid && en),
    .in_data (in_data),
    .conv    (conv_r),
    .persp   (persp_r),
    .side_o  (side_b),
    .num_o   (num),
    .den_o   (den)
  );

  for (genvar g = 0; g < opm_pkg::NLANES; g++) begin : g_lane
    opm_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (num[g]),
      .den (den[g]),
      .quo (res[g])
    );
  end

  opm_pkg::side_t side_r [opm_pkg::LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < opm_pkg::LANE_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[0] <= side_b;
      for (int i = 1; i < opm_pkg::LANE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  opm_pkg::side_t     tail;
  opm_pkg::out_item_t item_nxt, out_data_r;

  always_comb begin
    tail     = side_r[opm_pkg::LANE_LAT-1];
    item_nxt = '0;
    item_nxt.degenerate = tail.degen;
    if (!tail.degen) begin
      item_nxt.scale_x      = res[opm_pkg::L_SX];
      item_nxt.scale_y      = res[opm_pkg::L_SY];
      item_nxt.depth_scale  = res[opm_pkg::L_DS];
      item_nxt.depth_offset = res[opm_pkg::L_DO];
      if (tail.persp) begin
        item_nxt.skew_x   = res[opm_pkg::L_KX];
        item_nxt.skew_y   = res[opm_pkg::L_KY];
        item_nxt.w_from_z = (tail.conv == opm_pkg::CONV_LH_Z01) ? opm_pkg::Q_ONE
                                                                 : opm_pkg::Q_M_ONE;
      end else begin
        item_nxt.offset_x   = res[opm_pkg::L_KX];
        item_nxt.offset_y   = res[opm_pkg::L_KY];
        item_nxt.w_constant = opm_pkg::Q_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
